// File: src/canonical_kmer_repeat_marker_assert.svh
// Assertion macros for the canonical k-mer repeat marker.
// Expect clk and rst_n in the scope of use.
`ifndef CANONICAL_KMER_REPEAT_MARKER_ASSERT_SVH
`define CANONICAL_KMER_REPEAT_MARKER_ASSERT_SVH

// Same-cycle implication.
`define CKRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ckrm assertion failed");

// Next-cycle implication.
`define CKRM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ckrm assertion failed");

`endif

// File: src/ckrm_pkg.sv
// Shared types and constants of the canonical k-mer repeat marker.
// No dependencies.
package ckrm_pkg;

  localparam int MAX_KMER_DEF = 10;
  localparam int IDX_W  = 20;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 4;
  localparam int CNT_W  = 40;

  localparam logic [LEN_W-1:0] KMER_RESET = LEN_W'(10);

  localparam logic ACT_FEED  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
  localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
  localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
  localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
  localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
  localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_t;

  typedef struct packed {
    logic once;
    logic twice;
  } flags_t;

  function automatic base_t base_decode(input logic [CHAR_W-1:0] ch);
    base_t b;
    b.ok   = 1'b1;
    b.code = 2'd0;
    case (ch)
      CH_A_UP, CH_A_LO: b.code = 2'd0;
      CH_C_UP, CH_C_LO: b.code = 2'd1;
      CH_G_UP, CH_G_LO: b.code = 2'd2;
      CH_T_UP, CH_T_LO: b.code = 2'd3;
      default:          b.ok   = 1'b0;
    endcase
    return b;
  endfunction

endpackage

// File: src/ckrm_if.sv
// Item channels of the canonical k-mer repeat marker.
// Depends on ckrm_pkg.
interface ckrm_in_if
  import ckrm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              action;
  logic [CHAR_W-1:0] base_char;
  logic [IDX_W-1:0]  query_index;

  modport source (output valid, action, base_char, query_index, input ready);
  modport sink   (input valid, action, base_char, query_index, output ready);
endinterface

interface ckrm_out_if
  import ckrm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             window_valid;
  logic [IDX_W-1:0] canonical_index;
  logic             was_seen_once;
  logic             was_seen_twice;
  logic [CNT_W-1:0] valid_window_total;

  modport source (output valid, window_valid, canonical_index, was_seen_once,
                  was_seen_twice, valid_window_total, input ready);
  modport sink   (input valid, window_valid, canonical_index, was_seen_once,
                  was_seen_twice, valid_window_total, output ready);
endinterface

// File: src/ckrm_roller.sv
// Rolling forward and reverse-complement codes, window length and run count.
// Depends on ckrm_pkg.
module ckrm_roller
  import ckrm_pkg::*;
#(
  parameter int MaxKmer = MAX_KMER_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [LEN_W-1:0]       cfg_len,
  input  logic                   step,
  input  logic [CHAR_W-1:0]      base_char,
  output logic                   hit,
  output logic [2*MaxKmer-1:0]   canon
);

  localparam int AW = 2 * MaxKmer;

  logic [LEN_W-1:0] len_r;
  logic [AW-1:0]    fwd_r, fwd_nxt;
  logic [AW-1:0]    rc_r, rc_nxt;
  logic [LEN_W-1:0] run_r, run_nxt;
  logic [LEN_W-1:0] k;
  logic [AW-1:0]    kmask;
  logic [AW-1:0]    fwd_sh, rc_sh;
  base_t            b;

  assign b = base_decode(base_char);

  always_comb begin
    if (len_r == '0) begin
      k = LEN_W'(1);
    end else if (int'(len_r) > MaxKmer) begin
      k = LEN_W'(MaxKmer);
    end else begin
      k = len_r;
    end
  end

  always_comb begin
    fwd_sh = AW'({fwd_r, b.code});
    rc_sh  = rc_r >> 2;
    for (int j = 0; j < MaxKmer; j++) begin
      kmask[2*j +: 2]   = (j < int'(k)) ? 2'b11 : 2'b00;
      fwd_nxt[2*j +: 2] = fwd_sh[2*j +: 2] & kmask[2*j +: 2];
      rc_nxt[2*j +: 2]  = (j == int'(k) - 1) ? ~b.code : (rc_sh[2*j +: 2] & kmask[2*j +: 2]);
    end
    run_nxt = (run_r < k) ? run_r + LEN_W'(1) : run_r;
  end

  assign hit   = b.ok && (run_nxt >= k);
  assign canon = (fwd_nxt < rc_nxt) ? fwd_nxt : rc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= KMER_RESET;
      fwd_r <= '0;
      rc_r  <= '0;
      run_r <= '0;
    end else if (cfg_we) begin
      len_r <= cfg_len;
      fwd_r <= '0;
      rc_r  <= '0;
      run_r <= '0;
    end else if (step) begin
      if (b.ok) begin
        fwd_r <= fwd_nxt;
        rc_r  <= rc_nxt;
        run_r <= run_nxt;
      end else begin
        fwd_r <= '0;
        rc_r  <= '0;
        run_r <= '0;
      end
    end
  end

endmodule

// File: src/ckrm_flag_mem.sv
// Seen-once and seen-twice flag memory with clearing sweep and write forwarding.
// Depends on ckrm_pkg.
module ckrm_flag_mem
  import ckrm_pkg::*;
#(
  parameter int MaxKmer = MAX_KMER_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 busy,
  input  logic                 re,
  input  logic [2*MaxKmer-1:0] raddr,
  input  logic [2*MaxKmer-1:0] look_addr,
  output flags_t               look_flags,
  input  logic                 we,
  input  logic [2*MaxKmer-1:0] waddr,
  input  flags_t               wdata
);

  localparam int AW    = 2 * MaxKmer;
  localparam int DEPTH = 1 << AW;

  flags_t          mem [DEPTH];
  flags_t          rd_r;
  logic            clr_busy_r;
  logic [AW-1:0]   clr_addr_r;
  logic            fwd_vld_r;
  logic [AW-1:0]   fwd_addr_r;
  flags_t          fwd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  flags_t          mem_wdata;

  assign busy      = clr_busy_r;
  assign mem_we    = clr_busy_r || we;
  assign mem_waddr = clr_busy_r ? clr_addr_r : waddr;
  assign mem_wdata = clr_busy_r ? flags_t'('0) : wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (&clr_addr_r) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (we && !clr_busy_r) begin
      fwd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we && !clr_busy_r) begin
      fwd_addr_r <= waddr;
      fwd_data_r <= wdata;
    end
  end

  assign look_flags = (fwd_vld_r && fwd_addr_r == look_addr) ? fwd_data_r : rd_r;

endmodule

// File: src/canonical_kmer_repeat_marker.sv
// Canonical k-mer repeat marker: an accepted item passes the s1 register, then the
// output register. Throughput one item per cycle unless sweeping or held by the output;
// the flag memory is read on accept and written back as the item leaves s1, with the
// last write forwarded to the next lookup. Synchronous active-low reset clears codes,
// count and control, then sweeps the flag memory one entry a cycle over its
// 2**(2*MaxKmer) entries (1048576 at MaxKmer 10), during which no item is taken.
`include "canonical_kmer_repeat_marker_assert.svh"

module canonical_kmer_repeat_marker
  import ckrm_pkg::*;
#(
  parameter int MaxKmer = MAX_KMER_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  ckrm_in_if.sink           in_if,
  ckrm_out_if.source        out_if
);

  localparam int AW = 2 * MaxKmer;

  logic             mem_busy;
  logic             in_acc, feed, query;
  logic             s1_adv;
  logic             hit;
  logic [AW-1:0]    canon;
  logic [AW-1:0]    qaddr;
  logic [IDX_W+AW-1:0] qext;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             s1_valid_r;
  logic             s1_query_r;
  logic             s1_window_r;
  logic [AW-1:0]    s1_addr_r;
  logic [CNT_W-1:0] s1_total_r;
  flags_t           s1_flags;
  flags_t           wr_flags;
  logic             s1_show;
  logic [IDX_W+AW-1:0] cext;

  logic             out_valid_r;
  logic             out_window_r;
  logic [IDX_W-1:0] out_index_r;
  logic             out_once_r;
  logic             out_twice_r;
  logic [CNT_W-1:0] out_total_r;

  assign s1_adv      = !out_valid_r || out_if.ready;
  assign in_if.ready = !mem_busy && (!s1_valid_r || s1_adv);
  assign in_acc      = in_if.valid && in_if.ready;
  assign feed        = in_acc && (in_if.action == ACT_FEED);
  assign query       = in_acc && (in_if.action == ACT_QUERY);

  assign qext  = {AW'(0), in_if.query_index};
  assign qaddr = qext[AW-1:0];

  ckrm_roller #(.MaxKmer(MaxKmer)) u_roller (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_wr_en),
    .cfg_len   (cfg_wr_data),
    .step      (feed),
    .base_char (in_if.base_char),
    .hit       (hit),
    .canon     (canon)
  );

  assign count_nxt = (feed && hit && !(&count_r)) ? count_r + CNT_W'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign wr_flags.once  = 1'b1;
  assign wr_flags.twice = s1_flags.twice || s1_flags.once;

  ckrm_flag_mem #(.MaxKmer(MaxKmer)) u_flag_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (mem_busy),
    .re         (query || (feed && hit)),
    .raddr      (query ? qaddr : canon),
    .look_addr  (s1_addr_r),
    .look_flags (s1_flags),
    .we         (s1_valid_r && s1_window_r && s1_adv),
    .waddr      (s1_addr_r),
    .wdata      (wr_flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_query_r  <= query;
      s1_window_r <= feed && hit;
      s1_addr_r   <= query ? qaddr : canon;
      s1_total_r  <= count_nxt;
    end
  end

  assign s1_show = s1_query_r || s1_window_r;
  assign cext    = {IDX_W'(0), s1_addr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_window_r <= s1_show;
      out_index_r  <= s1_show ? cext[IDX_W-1:0] : '0;
      out_once_r   <= s1_show && s1_flags.once;
      out_twice_r  <= s1_show && s1_flags.twice;
      out_total_r  <= s1_total_r;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.window_valid       = out_window_r;
  assign out_if.canonical_index    = out_index_r;
  assign out_if.was_seen_once      = out_once_r;
  assign out_if.was_seen_twice     = out_twice_r;
  assign out_if.valid_window_total = out_total_r;

  `CKRM_ASSERT_IMP(a_no_accept_in_sweep, in_if.valid && in_if.ready, !mem_busy)
  `CKRM_ASSERT_IMP(a_twice_needs_once, out_if.valid && out_if.was_seen_twice,
                   out_if.was_seen_once)
  `CKRM_ASSERT_IMP(a_blank_result, out_if.valid && !out_if.window_valid,
                   out_if.canonical_index == '0 && !out_if.was_seen_once)
  `CKRM_ASSERT_NXT(a_accept_fills_s1, in_if.valid && in_if.ready, s1_valid_r)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the canonical k-mer repeat marker.
// Depends on ckrm_pkg, the ckrm_in_if and ckrm_out_if channels and the block itself.
// Runs directed and random base streams with queries and compares every result item.
module testbench;
  import ckrm_pkg::*;

  localparam int IDLE_LIMIT   = 3 * (1 << (2 * MAX_KMER_DEF));
  localparam int STALL_CYCLES = 400;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS  = 10;
  localparam int LOG_DEPTH    = 64;

  localparam logic [CHAR_W-1:0] CH_N_UP = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_N_LO = 8'h6E;

  typedef struct packed {
    logic             window_valid;
    logic [IDX_W-1:0] canonical_index;
    logic             was_seen_once;
    logic             was_seen_twice;
    logic [CNT_W-1:0] valid_window_total;
  } mark_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  ckrm_in_if  in_ch ();
  ckrm_out_if out_ch ();

  canonical_kmer_repeat_marker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #1 clk = ~clk;

  logic [LEN_W-1:0] kmer_len = KMER_RESET;
  logic [IDX_W-1:0] fwd_code = '0;
  logic [IDX_W-1:0] rc_code  = '0;
  int               run_len  = 0;
  logic [CNT_W-1:0] window_total = '0;
  bit               once_bits  [0:(1 << IDX_W) - 1];
  bit               twice_bits [0:(1 << IDX_W) - 1];

  mark_t            mark_queue [$];
  logic [IDX_W-1:0] recent_canon [$];
  logic [CHAR_W-1:0] base_log [$];

  int  mismatches   = 0;
  int  item_count   = 0;
  int  window_count = 0;
  int  query_count  = 0;
  int  repeat_hits  = 0;
  int  idle_cycles  = 0;
  bit  steady       = 1'b0;
  int  stall_token  = 0;
  int  stall_taken  = 0;
  int  hold_left    = 0;

  function automatic int base_value(input logic [CHAR_W-1:0] ch);
    case (ch)
      CH_A_UP, CH_A_LO: return 0;
      CH_C_UP, CH_C_LO: return 1;
      CH_G_UP, CH_G_LO: return 2;
      CH_T_UP, CH_T_LO: return 3;
      default:          return -1;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] random_base();
    case ($urandom_range(0, 7))
      0:       return CH_A_UP;
      1:       return CH_C_UP;
      2:       return CH_G_UP;
      3:       return CH_T_UP;
      4:       return CH_A_LO;
      5:       return CH_C_LO;
      6:       return CH_G_LO;
      default: return CH_T_LO;
    endcase
  endfunction

  function automatic mark_t predict_mark(input logic act, input logic [CHAR_W-1:0] ch,
                                         input logic [IDX_W-1:0] qidx);
    mark_t            m;
    int               k;
    int               c;
    logic [IDX_W-1:0] kmask;
    logic [IDX_W-1:0] canon;
    m = '0;
    k = (kmer_len == 0) ? 1 : (kmer_len > MAX_KMER_DEF) ? MAX_KMER_DEF : int'(kmer_len);
    kmask = IDX_W'((32'd1 << (2 * k)) - 32'd1);
    if (act == ACT_QUERY) begin
      query_count++;
      m.window_valid       = 1'b1;
      m.canonical_index    = qidx;
      m.was_seen_once      = once_bits[qidx];
      m.was_seen_twice     = twice_bits[qidx];
      m.valid_window_total = window_total;
      return m;
    end
    c = base_value(ch);
    if (c < 0) begin
      fwd_code = '0;
      rc_code  = '0;
      run_len  = 0;
    end else begin
      fwd_code = ((fwd_code << 2) | IDX_W'(c)) & kmask;
      rc_code  = ((rc_code >> 2) | (IDX_W'(3 - c) << (2 * (k - 1)))) & kmask;
      if (run_len < k) run_len++;
      if (run_len >= k) begin
        canon = (fwd_code < rc_code) ? fwd_code : rc_code;
        m.window_valid    = 1'b1;
        m.canonical_index = canon;
        m.was_seen_once   = once_bits[canon];
        m.was_seen_twice  = twice_bits[canon];
        if (window_total != {CNT_W{1'b1}}) window_total++;
        if (!once_bits[canon]) once_bits[canon] = 1'b1;
        else if (!twice_bits[canon]) twice_bits[canon] = 1'b1;
        window_count++;
        if (m.was_seen_once) repeat_hits++;
        recent_canon.push_back(canon);
        if (recent_canon.size() > LOG_DEPTH) void'(recent_canon.pop_front());
      end
    end
    m.valid_window_total = window_total;
    return m;
  endfunction

  task automatic push_item(input logic act, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] qidx);
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.base_char   <= ch;
    in_ch.query_index <= qidx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    mark_queue.push_back(predict_mark(act, ch, qidx));
    item_count++;
  endtask

  task automatic feed_string(input string s);
    for (int i = 0; i < s.len(); i++) push_item(ACT_FEED, s[i], IDX_W'($urandom));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (mark_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] len);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    kmer_len = len;
    fwd_code = '0;
    rc_code  = '0;
    run_len  = 0;
  endtask

  task automatic send_query();
    logic [IDX_W-1:0] qidx;
    case ($urandom_range(0, 9))
      0:       qidx = '0;
      1:       qidx = '1;
      2, 3, 4: qidx = IDX_W'($urandom);
      default: qidx = (recent_canon.size() != 0) ?
                      recent_canon[$urandom_range(0, recent_canon.size() - 1)] :
                      IDX_W'($urandom);
    endcase
    push_item(ACT_QUERY, CHAR_W'($urandom), qidx);
  endtask

  task automatic run_random_stream(input int n_target);
    int               sent;
    int               r;
    int               start;
    int               span;
    logic [CHAR_W-1:0] ch;
    sent = 0;
    while (sent < n_target) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_query();
        sent++;
      end else if (r < 19) begin
        ch = ($urandom_range(0, 1) != 0) ? CHAR_W'($urandom_range(0, 255)) :
             (($urandom_range(0, 1) != 0) ? CH_N_UP : CH_N_LO);
        push_item(ACT_FEED, ch, IDX_W'($urandom));
        sent++;
      end else if (r < 34 && base_log.size() >= 12) begin
        span  = $urandom_range(4, 12);
        start = $urandom_range(0, base_log.size() - span);
        for (int i = 0; i < span; i++)
          push_item(ACT_FEED, base_log[start + i], IDX_W'($urandom));
        sent += span;
      end else begin
        ch = random_base();
        push_item(ACT_FEED, ch, IDX_W'($urandom));
        base_log.push_back(ch);
        if (base_log.size() > LOG_DEPTH) void'(base_log.pop_front());
        sent++;
      end
    end
  endtask

  task automatic test_reset_length();
    feed_string("AcGtTgCaAC");
    push_item(ACT_QUERY, 8'h00, recent_canon[$]);
    push_item(ACT_QUERY, 8'hFF, '0);
    push_item(ACT_QUERY, 8'h00, '1);
  endtask

  task automatic test_short_length();
    set_length(LEN_W'(1));
    feed_string("ATa");
    push_item(ACT_FEED, CH_N_UP, '0);
    push_item(ACT_FEED, CH_N_LO, '1);
    push_item(ACT_FEED, 8'hFF, '0);
    push_item(ACT_QUERY, 8'hFF, '0);
  endtask

  task automatic test_length_clamp_and_restart();
    set_length(LEN_W'(0));
    push_item(ACT_FEED, CH_G_UP, '0);
    set_length(LEN_W'(2));
    push_item(ACT_FEED, CH_A_UP, '0);
    set_length(LEN_W'(2));
    push_item(ACT_FEED, CH_C_UP, '0);
  endtask

  task automatic test_random_lengths();
    set_length(LEN_W'(1));
    run_random_stream(120);
    set_length(LEN_W'(10));
    run_random_stream(160);
    set_length(LEN_W'(3));
    run_random_stream(110);
    set_length(LEN_W'(15));
    run_random_stream(90);
    set_length(LEN_W'(0));
    run_random_stream(50);
    set_length(LEN_W'(7));
    run_random_stream(100);
  endtask

  task automatic test_steady_stream();
    set_length(LEN_W'(6));
    steady <= 1'b1;
    run_random_stream(120);
    steady <= 1'b0;
  endtask

  task automatic test_output_stall();
    set_length(LEN_W'(2));
    stall_token <= stall_token + 1;
    run_random_stream(100);
  endtask

  always @(posedge clk) begin
    if (stall_token != stall_taken) begin
      stall_taken  <= stall_token;
      hold_left    <= STALL_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 14);
    end
  end

  always @(posedge clk) begin
    mark_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (mark_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result item: idx=%h total=%0d",
                   out_ch.canonical_index, out_ch.valid_window_total);
      end else begin
        want = mark_queue.pop_front();
        if (out_ch.window_valid !== want.window_valid ||
            out_ch.canonical_index !== want.canonical_index ||
            out_ch.was_seen_once !== want.was_seen_once ||
            out_ch.was_seen_twice !== want.was_seen_twice ||
            out_ch.valid_window_total !== want.valid_window_total) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: expected win=%0b idx=%h once=%0b twice=%0b total=%0d,",
                      " got win=%0b idx=%h once=%0b twice=%0b total=%0d"},
                     want.window_valid, want.canonical_index, want.was_seen_once,
                     want.was_seen_twice, want.valid_window_total, out_ch.window_valid,
                     out_ch.canonical_index, out_ch.was_seen_once, out_ch.was_seen_twice,
                     out_ch.valid_window_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_FEED;
    in_ch.base_char   = '0;
    in_ch.query_index = '0;
    out_ch.ready      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_length();
    test_short_length();
    test_length_clamp_and_restart();
    test_random_lengths();
    test_steady_stream();
    test_output_stall();
    wait_drained();
    $display("Run covered %0d items: %0d full windows, %0d repeat hits, %0d queries,",
             item_count, window_count, repeat_hits, query_count);
    $display("window lengths 0 to 15 with clamping, restarts, idle gaps and a long output stall.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failing result items", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/ckrm_pkg.sv
src/ckrm_if.sv
src/ckrm_roller.sv
src/ckrm_flag_mem.sv
src/canonical_kmer_repeat_marker.sv
tb/testbench.sv
